FILE: rtl/cbbq_pkg.sv
// ----------------------------------------------------------------------------
// Coalescing byte budget queue package
// Shared sizes, the stored frame descriptor type, the operation codes, the register address and the budget reset value.
// ----------------------------------------------------------------------------
package cbbq_pkg;

  localparam int DEPTH = 16;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int BW = 21;

  localparam logic [1:0] FUNC_PUSH = 2'd0;
  localparam logic [1:0] FUNC_POP = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_STATUS = 2'd3;

  localparam logic [2:0] ADDR_BYTE_BUDGET = 3'd0;

  localparam logic [BW-1:0] BUDGET_RESET = 21'd65536;

  typedef struct packed {
    logic        keyframe;
    logic [31:0] baseline;
    logic [15:0] length;
    logic [15:0] tag;
  } entry_t;

endpackage

FILE: rtl/coalescing_byte_budget_queue_core.sv
// ----------------------------------------------------------------------------
// Coalescing byte budget queue core
// Frame descriptor queue with delta coalescing, a byte budget and a sticky
// resync flag, run by a small sequencer over one descriptor store.
// ----------------------------------------------------------------------------
// An operation is taken when start is high and busy is low, and its result is
// shown for one cycle with done high; the receiver cannot stall, so the result
// must be captured in that cycle. Clear, status and a pop of an empty queue go
// straight to finish; any other pop reads the head entry, then takes it. A push
// reads and checks each queued frame for coalescing, appends, checks the budget
// and drops frames from the head, each with a read and a take step; the steps
// are set by the one registered read port of the descriptor store.
module coalescing_byte_budget_queue_core (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  logic                    start,
  output logic                    busy,
  output logic                    done,
  input  logic [1:0]              func,
  input  logic                    in_is_keyframe,
  input  logic [31:0]             in_baseline,
  input  logic [15:0]             in_length,
  input  logic [15:0]             in_tag,
  output logic                    pop_valid,
  output logic                    out_is_keyframe,
  output logic [31:0]             out_baseline,
  output logic [15:0]             out_length,
  output logic [15:0]             out_tag,
  output logic [4:0]              entry_count,
  output logic [20:0]             queued_bytes,
  output logic                    resync_flag
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRD  = 3'd1;
  localparam logic [2:0] S_SCHK = 3'd2;
  localparam logic [2:0] S_APP  = 3'd3;
  localparam logic [2:0] S_BCHK = 3'd4;
  localparam logic [2:0] S_DRD  = 3'd5;
  localparam logic [2:0] S_DEX  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  logic [2:0]               state;
  logic [cbbq_pkg::BW-1:0]  byte_budget;
  logic [cbbq_pkg::AW-1:0]  head;
  logic [cbbq_pkg::CW-1:0]  occ;
  logic [cbbq_pkg::BW-1:0]  total;
  logic                     sticky;
  logic [cbbq_pkg::CW-1:0]  rd_idx;
  logic [cbbq_pkg::CW-1:0]  wr_idx;
  logic                     pre_drop;
  logic                     is_pop;
  cbbq_pkg::entry_t         item;
  cbbq_pkg::entry_t         pop_q;
  logic                     pop_hit;

  cbbq_pkg::entry_t         mem [cbbq_pkg::DEPTH];
  cbbq_pkg::entry_t         rd_q;
  logic [cbbq_pkg::AW-1:0]  rd_addr;
  logic                     we;
  logic [cbbq_pkg::AW-1:0]  wa;
  cbbq_pkg::entry_t         wd;
  logic                     match;
  logic [cbbq_pkg::CW-1:0]  rd_idx_next;

  assign pready = 1'b1;
  assign busy = (state != S_IDLE);
  assign prdata = paddr[2] ? 32'd0 : {{(32 - cbbq_pkg::BW){1'b0}}, byte_budget};

  assign match = !rd_q.keyframe && (rd_q.baseline == item.baseline);
  assign rd_idx_next = rd_idx + 1'b1;

  always_comb begin
    rd_addr = head;
    if (state == S_SRD) begin
      rd_addr = head + rd_idx[cbbq_pkg::AW-1:0];
    end
  end

  always_comb begin
    we = 1'b0;
    wa = head + wr_idx[cbbq_pkg::AW-1:0];
    wd = rd_q;
    if (state == S_SCHK && !match) begin
      we = 1'b1;
    end else if (state == S_APP && occ != cbbq_pkg::CW'(cbbq_pkg::DEPTH)) begin
      we = 1'b1;
      wa = head + occ[cbbq_pkg::AW-1:0];
      wd = item;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_budget <= cbbq_pkg::BUDGET_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      byte_budget <= pwdata[cbbq_pkg::BW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      head <= '0;
      occ <= '0;
      total <= '0;
      sticky <= 1'b0;
      done <= 1'b0;
      pre_drop <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            item <= '{in_is_keyframe, in_baseline, in_length, in_tag};
            pop_hit <= 1'b0;
            pop_q <= '0;
            is_pop <= 1'b0;
            rd_idx <= '0;
            wr_idx <= '0;
            pre_drop <= 1'b0;
            state <= S_FIN;
            if (func == cbbq_pkg::FUNC_PUSH) begin
              if (in_is_keyframe) begin
                occ <= '0;
                total <= '0;
                state <= S_APP;
              end else if (occ == '0) begin
                state <= S_APP;
              end else begin
                state <= S_SRD;
              end
            end else if (func == cbbq_pkg::FUNC_POP) begin
              if (occ != '0) begin
                is_pop <= 1'b1;
                state <= S_DRD;
              end
            end else if (func == cbbq_pkg::FUNC_CLEAR) begin
              sticky <= 1'b0;
            end
          end
        end
        S_SRD: begin
          state <= S_SCHK;
        end
        S_SCHK: begin
          rd_idx <= rd_idx_next;
          if (match) begin
            total <= total - cbbq_pkg::BW'(rd_q.length);
          end else begin
            wr_idx <= wr_idx + 1'b1;
          end
          if (rd_idx_next == occ) begin
            occ <= match ? wr_idx : wr_idx + 1'b1;
            state <= S_APP;
          end else begin
            state <= S_SRD;
          end
        end
        S_APP: begin
          if (occ == cbbq_pkg::CW'(cbbq_pkg::DEPTH)) begin
            pre_drop <= 1'b1;
            state <= S_DRD;
          end else begin
            occ <= occ + 1'b1;
            total <= total + cbbq_pkg::BW'(item.length);
            state <= S_BCHK;
          end
        end
        S_BCHK: begin
          if (total > byte_budget && occ > cbbq_pkg::CW'(1)) begin
            state <= S_DRD;
          end else begin
            state <= S_FIN;
          end
        end
        S_DRD: begin
          state <= S_DEX;
        end
        S_DEX: begin
          total <= total - cbbq_pkg::BW'(rd_q.length);
          head <= head + 1'b1;
          occ <= occ - 1'b1;
          if (is_pop) begin
            pop_hit <= 1'b1;
            pop_q <= rd_q;
            state <= S_FIN;
          end else begin
            sticky <= 1'b1;
            if (pre_drop) begin
              pre_drop <= 1'b0;
              state <= S_APP;
            end else begin
              state <= S_BCHK;
            end
          end
        end
        S_FIN: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN) begin
      pop_valid <= pop_hit;
      out_is_keyframe <= pop_q.keyframe;
      out_baseline <= pop_q.baseline;
      out_length <= pop_q.length;
      out_tag <= pop_q.tag;
      entry_count <= occ;
      queued_bytes <= total;
      resync_flag <= sticky;
    end
  end

endmodule
